// ===== rtl/rabs_pkg.sv =====
package rabs_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    // reciprocal dividend is 2^(2*FRAC_BITS); one quotient bit per divider step
    localparam int QUOT_BITS  = 2 * FRAC_BITS + 1;
    localparam int DIV_STEPS  = QUOT_BITS;
    localparam int RECIP_LAT  = DIV_STEPS + 1;
    localparam int PROD_BITS  = 2 * WORD_BITS;
    localparam int SHIFT_BITS = PROD_BITS - FRAC_BITS;
    localparam int AXES       = 3;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [WORD_BITS:0]   diff_t;
    typedef logic        [WORD_BITS-1:0] umag_t;
    typedef logic        [PROD_BITS-1:0] prod_t;
    typedef logic        [SHIFT_BITS-1:0] scaled_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    // scale a product magnitude back to Q.FRAC_BITS, apply sign, saturate
    function automatic word_t sat_scale(input prod_t prod, input logic neg);
        scaled_t s;
        scaled_t lim_pos;
        scaled_t lim_neg;
        word_t   res;
        s       = scaled_t'(prod >> FRAC_BITS);
        lim_pos = scaled_t'(umag_t'(WORD_MAX));
        lim_neg = scaled_t'(umag_t'(WORD_MIN));
        if (neg)
        begin
            if (s > lim_neg)
                res = WORD_MIN;
            else
                res = -word_t'(s);
        end
        else
        begin
            if (s > lim_pos)
                res = WORD_MAX;
            else
                res = word_t'(s);
        end
        return res;
    endfunction

endpackage

// ===== rtl/rabs_recip.sv =====
module rabs_recip
    import rabs_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  word_t d,
    output word_t recip
);

    umag_t                m_reg    [DIV_STEPS];
    umag_t                rem_reg  [DIV_STEPS];
    logic [QUOT_BITS-1:0] q_reg    [DIV_STEPS];
    logic                 neg_reg  [DIV_STEPS];
    logic                 zero_reg [DIV_STEPS];
    word_t                recip_reg;
    word_t                recip_next;

    // restoring division, one quotient bit per stage
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_step
        localparam logic DBIT = (i == 0);
        umag_t                m_in;
        umag_t                rem_in;
        logic [QUOT_BITS-1:0] q_in;
        logic                 neg_in;
        logic                 zero_in;
        logic [WORD_BITS:0]   trial;
        logic [WORD_BITS:0]   rest;
        logic                 take;

        if (i == 0)
        begin : g_first
            assign m_in    = d[WORD_BITS-1] ? umag_t'(~d) + umag_t'(1) : umag_t'(d);
            assign rem_in  = '0;
            assign q_in    = '0;
            assign neg_in  = d[WORD_BITS-1];
            assign zero_in = (d == '0);
        end
        else
        begin : g_rest
            assign m_in    = m_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign q_in    = q_reg[i-1];
            assign neg_in  = neg_reg[i-1];
            assign zero_in = zero_reg[i-1];
        end

        assign trial = {rem_in, DBIT};
        assign take  = (trial >= {1'b0, m_in});
        assign rest  = take ? (trial - {1'b0, m_in}) : trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[i]    <= m_in;
                rem_reg[i]  <= rest[WORD_BITS-1:0];
                q_reg[i]    <= q_in | (QUOT_BITS'(take) << (QUOT_BITS - 1 - i));
                neg_reg[i]  <= neg_in;
                zero_reg[i] <= zero_in;
            end
        end
    end

    always_comb
    begin
        logic [QUOT_BITS+WORD_BITS-1:0] q_wide;
        logic [QUOT_BITS+WORD_BITS-1:0] lim_wide;
        q_wide   = (QUOT_BITS+WORD_BITS)'(q_reg[DIV_STEPS-1]);
        lim_wide = (QUOT_BITS+WORD_BITS)'(umag_t'(WORD_MAX));
        if (zero_reg[DIV_STEPS-1])
            recip_next = WORD_MAX;
        else if (q_wide > lim_wide)
            recip_next = neg_reg[DIV_STEPS-1] ? WORD_MIN : WORD_MAX;
        else if (neg_reg[DIV_STEPS-1])
            recip_next = -word_t'(q_reg[DIV_STEPS-1]);
        else
            recip_next = word_t'(q_reg[DIV_STEPS-1]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            recip_reg <= recip_next;
    end

    assign recip = recip_reg;

endmodule

// ===== rtl/ray_aabb_slab_intersect_unit.sv =====
// Ray versus axis-aligned box test, slab method, signed Q16.16.
// Stages in order: divider and offset delay line, multiply, scale, x/y combine, z fold, pick.
// Throughput: one beat per cycle; the reciprocal divider is fully pipelined, one bit a stage.
// The whole pipe holds while a result beat waits at the output and res_ready is low.
// Reset (rst_n, async, active low) clears all valid bits; data registers are not reset.
module ray_aabb_slab_intersect_unit
    import rabs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  ray_valid,
    output logic                  ray_ready,
    input  word_t                 box_min_x,
    input  word_t                 box_min_y,
    input  word_t                 box_min_z,
    input  word_t                 box_max_x,
    input  word_t                 box_max_y,
    input  word_t                 box_max_z,
    input  word_t                 origin_x,
    input  word_t                 origin_y,
    input  word_t                 origin_z,
    input  word_t                 dir_x,
    input  word_t                 dir_y,
    input  word_t                 dir_z,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic                  hit,
    output logic [WORD_BITS-2:0]  t_hit
);

    logic  advance;

    word_t bmin  [AXES];
    word_t bmax  [AXES];
    word_t org   [AXES];
    word_t dir   [AXES];
    word_t recip [AXES];

    // delay line that keeps slab offsets aligned with the divider
    logic  line_valid_reg [RECIP_LAT];
    diff_t near_reg       [RECIP_LAT][AXES];
    diff_t far_reg        [RECIP_LAT][AXES];

    // multiply stage
    logic  m1_valid_reg;
    prod_t pn_reg [AXES];
    prod_t pf_reg [AXES];
    logic  nn_reg [AXES];
    logic  nf_reg [AXES];

    // scale and saturate stage
    logic  m2_valid_reg;
    word_t tn_reg [AXES];
    word_t tf_reg [AXES];

    // interval combine stages
    logic  c1_valid_reg;
    logic  c1_miss_reg;
    word_t c1_tmin_reg;
    word_t c1_tmax_reg;
    word_t c1_zn_reg;
    word_t c1_zf_reg;

    logic  c2_valid_reg;
    logic  c2_miss_reg;
    word_t c2_tmin_reg;
    word_t c2_tmax_reg;

    logic                 res_valid_reg;
    logic                 hit_reg;
    logic [WORD_BITS-2:0] t_hit_reg;

    // Advance the whole pipe unless a finished beat is still waiting.
    assign advance   = !res_valid_reg || res_ready;
    assign ray_ready = advance;

    assign bmin = '{box_min_x, box_min_y, box_min_z};
    assign bmax = '{box_max_x, box_max_y, box_max_z};
    assign org  = '{origin_x, origin_y, origin_z};
    assign dir  = '{dir_x, dir_y, dir_z};

    // One pipelined reciprocal per axis. The reciprocal is never zero in magnitude,
    // so its sign is the direction's sign (zero counts as positive).
    for (genvar a = 0; a < AXES; a++)
    begin : g_axis
        rabs_recip u_recip (
            .clk   (clk),
            .en    (advance),
            .d     (dir[a]),
            .recip (recip[a])
        );
    end

    // Entry: pick near and far bounds from the direction sign, form exact offsets.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                if (dir[a][WORD_BITS-1])
                begin
                    near_reg[0][a] <= diff_t'(bmax[a]) - diff_t'(org[a]);
                    far_reg[0][a]  <= diff_t'(bmin[a]) - diff_t'(org[a]);
                end
                else
                begin
                    near_reg[0][a] <= diff_t'(bmin[a]) - diff_t'(org[a]);
                    far_reg[0][a]  <= diff_t'(bmax[a]) - diff_t'(org[a]);
                end
            end
            for (int k = 1; k < RECIP_LAT; k++)
            begin
                near_reg[k] <= near_reg[k-1];
                far_reg[k]  <= far_reg[k-1];
            end
        end
    end

    // Multiply offset magnitude by reciprocal magnitude; the offset fits one word
    // in magnitude, so each product is a word by word multiply.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                diff_t dn;
                diff_t df;
                umag_t rmag;
                umag_t dnmag;
                umag_t dfmag;
                logic  rneg;
                dn    = near_reg[RECIP_LAT-1][a];
                df    = far_reg[RECIP_LAT-1][a];
                rneg  = recip[a][WORD_BITS-1];
                rmag  = rneg ? umag_t'(~recip[a]) + umag_t'(1) : umag_t'(recip[a]);
                dnmag = dn[WORD_BITS] ? umag_t'(-dn) : umag_t'(dn);
                dfmag = df[WORD_BITS] ? umag_t'(-df) : umag_t'(df);
                pn_reg[a] <= prod_t'(dnmag) * prod_t'(rmag);
                pf_reg[a] <= prod_t'(dfmag) * prod_t'(rmag);
                nn_reg[a] <= dn[WORD_BITS] ^ rneg;
                nf_reg[a] <= df[WORD_BITS] ^ rneg;
            end
        end
    end

    // Scale back to Q.FRAC_BITS and saturate.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                tn_reg[a] <= sat_scale(pn_reg[a], nn_reg[a]);
                tf_reg[a] <= sat_scale(pf_reg[a], nf_reg[a]);
            end
        end
    end

    // Intersect x and y intervals; hold z for the next stage.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c1_miss_reg <= (tn_reg[0] > tf_reg[1]) || (tn_reg[1] > tf_reg[0]);
            c1_tmin_reg <= (tn_reg[1] > tn_reg[0]) ? tn_reg[1] : tn_reg[0];
            c1_tmax_reg <= (tf_reg[1] < tf_reg[0]) ? tf_reg[1] : tf_reg[0];
            c1_zn_reg   <= tn_reg[2];
            c1_zf_reg   <= tf_reg[2];
        end
    end

    // Fold in z; an earlier miss sticks.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c2_miss_reg <= c1_miss_reg || (c1_tmin_reg > c1_zf_reg) || (c1_zn_reg > c1_tmax_reg);
            c2_tmin_reg <= (c1_zn_reg > c1_tmin_reg) ? c1_zn_reg : c1_tmin_reg;
            c2_tmax_reg <= (c1_zf_reg < c1_tmax_reg) ? c1_zf_reg : c1_tmax_reg;
        end
    end

    // Pick the nearest non-negative distance: entry, else exit when behind the origin.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (c2_miss_reg)
            begin
                hit_reg   <= 1'b0;
                t_hit_reg <= '0;
            end
            else if (!c2_tmin_reg[WORD_BITS-1])
            begin
                hit_reg   <= 1'b1;
                t_hit_reg <= c2_tmin_reg[WORD_BITS-2:0];
            end
            else if (!c2_tmax_reg[WORD_BITS-1])
            begin
                hit_reg   <= 1'b1;
                t_hit_reg <= c2_tmax_reg[WORD_BITS-2:0];
            end
            else
            begin
                hit_reg   <= 1'b0;
                t_hit_reg <= '0;
            end
        end
    end

    // Valid bits travel with the data and clear on reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < RECIP_LAT; k++)
                line_valid_reg[k] <= 1'b0;
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            c1_valid_reg  <= 1'b0;
            c2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            line_valid_reg[0] <= ray_valid;
            for (int k = 1; k < RECIP_LAT; k++)
                line_valid_reg[k] <= line_valid_reg[k-1];
            m1_valid_reg  <= line_valid_reg[RECIP_LAT-1];
            m2_valid_reg  <= m1_valid_reg;
            c1_valid_reg  <= m2_valid_reg;
            c2_valid_reg  <= c1_valid_reg;
            res_valid_reg <= c2_valid_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign hit       = hit_reg;
    assign t_hit     = t_hit_reg;

endmodule

// ===== rtl/rabs_checker.sv =====
module rabs_checker
    import rabs_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 ray_ready,
    input logic                 res_valid,
    input logic                 res_ready,
    input logic                 hit,
    input logic [WORD_BITS-2:0] t_hit
);

    // input side stalls exactly when a result beat is held
    a_ready_follows: assert property (@(posedge clk)
        ray_ready == (!res_valid || res_ready))
        else $error("ray_ready does not track output stall");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !hit) |-> (t_hit == '0))
        else $error("miss beat carries nonzero distance");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(hit) && $stable(t_hit)))
        else $error("stalled result beat changed");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !res_valid)
        else $error("result beat present out of reset");

endmodule

bind ray_aabb_slab_intersect_unit rabs_checker u_rabs_checker (.*);

// ===== sim/tb_ray_aabb_slab_intersect_unit.sv =====
`timescale 1ns / 100ps

// Ray versus axis-aligned box checker: stream rays through the slab unit and
// compare every result beat against a local fixed-point slab computation.
module tb_ray_aabb_slab_intersect_unit;
    import rabs_pkg::*;

    localparam int LATENCY   = DIV_STEPS + 6;
    localparam int N_RANDOM  = 1100;
    localparam int N_CALM    = 150;

    typedef struct {
        logic              hit;
        logic [WORD_BITS-2:0] t_hit;
    } slab_hit_t;

    // Hold the expected hit results in arrival order and compare result beats.
    class hit_scoreboard;
        slab_hit_t pending[$];
        int        n_errors;

        function new();
            n_errors = 0;
        endfunction

        function void note_ray(slab_hit_t e);
            pending.push_back(e);
        endfunction

        function void check_result(logic h, logic [WORD_BITS-2:0] t);
            slab_hit_t e;
            if (pending.size() == 0)
            begin
                $error("result beat with nothing pending: hit=%0b t_hit=%0h", h, t);
                n_errors++;
                return;
            end
            e = pending.pop_front();
            if (h !== e.hit)
            begin
                $error("hit: expected %0b actual %0b", e.hit, h);
                n_errors++;
            end
            if (t !== e.t_hit)
            begin
                $error("t_hit: expected %0h actual %0h", e.t_hit, t);
                n_errors++;
            end
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  ray_valid;
    logic  ray_ready;
    word_t box_min_x, box_min_y, box_min_z;
    word_t box_max_x, box_max_y, box_max_z;
    word_t origin_x, origin_y, origin_z;
    word_t dir_x, dir_y, dir_z;
    logic  res_valid;
    logic  res_ready;
    logic  hit;
    logic [WORD_BITS-2:0] t_hit;

    hit_scoreboard sb;
    bit            calm;       // no idling in the final stretch
    bit            stim_done;

    ray_aabb_slab_intersect_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .ray_valid (ray_valid),
        .ray_ready (ray_ready),
        .box_min_x (box_min_x),
        .box_min_y (box_min_y),
        .box_min_z (box_min_z),
        .box_max_x (box_max_x),
        .box_max_y (box_max_y),
        .box_max_z (box_max_z),
        .origin_x  (origin_x),
        .origin_y  (origin_y),
        .origin_z  (origin_z),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .dir_z     (dir_z),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .hit       (hit),
        .t_hit     (t_hit)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Slab arithmetic, done in wide signed integers.
    // ---------------------------------------------------------------
    localparam longint S_MAX = (longint'(1) <<< (WORD_BITS - 1)) - 1;
    localparam longint S_MIN = -S_MAX - 1;

    // 2^(2F)/d truncated toward zero; zero direction saturates positive
    function automatic longint inv_dir(longint d);
        longint q;
        longint m;
        if (d == 0)
            return S_MAX;
        m = (d < 0) ? -d : d;
        q = (longint'(1) <<< (2 * FRAC_BITS)) / m;
        if (d > 0)
            return (q > S_MAX) ? S_MAX : q;
        return (q > S_MAX) ? S_MIN : -q;
    endfunction

    // (a*b) >> F on the magnitude, signed after, saturated to a word
    function automatic longint scaled_product(longint a, longint b);
        logic [127:0] x;
        logic [127:0] y;
        logic [127:0] p;
        bit           neg;
        longint       lim;
        neg = (a < 0) != (b < 0);
        x   = (a < 0) ? 128'(-a) : 128'(a);
        y   = (b < 0) ? 128'(-b) : 128'(b);
        p   = (x * y) >> FRAC_BITS;
        lim = neg ? S_MAX + 1 : S_MAX;
        if (p > 128'(lim))
            return neg ? S_MIN : S_MAX;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic void slab_span(longint bmin, longint bmax, longint org, longint d,
                                      output longint tn, output longint tf);
        longint r;
        r  = inv_dir(d);
        tn = scaled_product(((r < 0) ? bmax : bmin) - org, r);
        tf = scaled_product(((r < 0) ? bmin : bmax) - org, r);
    endfunction

    function automatic slab_hit_t predict_hit();
        slab_hit_t e;
        longint    tmin, tmax, a0, a1;
        e.hit   = 1'b0;
        e.t_hit = '0;
        slab_span(box_min_x, box_max_x, origin_x, dir_x, tmin, tmax);
        slab_span(box_min_y, box_max_y, origin_y, dir_y, a0, a1);
        // drop out early once two intervals separate
        if (tmin > a1 || a0 > tmax)
            return e;
        if (a0 > tmin) tmin = a0;
        if (a1 < tmax) tmax = a1;
        slab_span(box_min_z, box_max_z, origin_z, dir_z, a0, a1);
        if (tmin > a1 || a0 > tmax)
            return e;
        if (a0 > tmin) tmin = a0;
        if (a1 < tmax) tmax = a1;
        if (tmin < 0)
        begin
            tmin = tmax;
            if (tmin < 0)
                return e;
        end
        e.hit   = 1'b1;
        e.t_hit = tmin[WORD_BITS-2:0];
        return e;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic word_t any_word();
        case ($urandom_range(0, 7))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            default: return word_t'($urandom);
        endcase
    endfunction

    // coordinate in a modest range so many rays actually meet the box
    function automatic word_t near_word(int span);
        return word_t'($signed($urandom_range(0, 2 * span)) - span) <<< FRAC_BITS
               | word_t'($urandom_range(0, 16'hffff));
    endfunction

    function automatic word_t dir_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return word_t'($signed($urandom_range(0, 6)) - 3);   // tiny: huge reciprocal
            2: return any_word();
            default: return near_word(4);
        endcase
    endfunction

    // Drive one ray beat and hold it until accepted.
    task automatic send_ray(word_t v[12]);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            ray_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        ray_valid <= 1'b1;
        box_min_x <= v[0];  box_min_y <= v[1];  box_min_z <= v[2];
        box_max_x <= v[3];  box_max_y <= v[4];  box_max_z <= v[5];
        origin_x  <= v[6];  origin_y  <= v[7];  origin_z  <= v[8];
        dir_x     <= v[9];  dir_y     <= v[10]; dir_z     <= v[11];
        @(posedge clk);
        while (!ray_ready)
            @(posedge clk);
        sb.note_ray(predict_hit());
        @(negedge clk);
    endtask

    task automatic random_ray(output word_t v[12]);
        word_t a;
        word_t b;
        int    span;
        if ($urandom_range(0, 9) == 0)
        begin
            // noise: anything at all, inverted boxes included
            foreach (v[i])
                v[i] = any_word();
            return;
        end
        span = ($urandom_range(0, 7) == 0) ? 20000 : 50;
        for (int ax = 0; ax < 3; ax++)
        begin
            a = near_word(span);
            b = near_word(span);
            // keep most boxes well formed
            if (a > b && $urandom_range(0, 15) != 0)
            begin
                v[ax]     = b;
                v[ax + 3] = a;
            end
            else
            begin
                v[ax]     = a;
                v[ax + 3] = b;
            end
            v[ax + 6] = near_word(span + 10);
            v[ax + 9] = dir_word();
        end
    endtask

    // ---------------------------------------------------------------
    // Result side: random stalls, sample at the rising edge
    // ---------------------------------------------------------------
    initial
    begin
        int gap;
        res_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 17);
                res_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_ready <= 1'b1;
        end
    end

    always @(posedge clk)
        if (rst_n && res_valid && res_ready)
            sb.check_result(hit, t_hit);

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        word_t v[12];
        sb        = new();
        calm      = 1'b0;
        stim_done = 1'b0;
        rst_n     = 1'b0;
        ray_valid = 1'b0;
        box_min_x = '0; box_min_y = '0; box_min_z = '0;
        box_max_x = '0; box_max_y = '0; box_max_z = '0;
        origin_x  = '0; origin_y  = '0; origin_z  = '0;
        dir_x     = '0; dir_y     = '0; dir_z     = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: unit box, ray along +x from outside -> hit at t=1
        v = '{-32'sh10000, -32'sh10000, -32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000,
              -32'sh20000, 0, 0, 32'sh10000, 0, 0};
        send_ray(v);
        // origin inside: tmin negative, tmax taken
        v = '{-32'sh10000, -32'sh10000, -32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000,
              0, 0, 0, -32'sh10000, 32'sh10000, 32'sh8000};
        send_ray(v);
        // box behind the ray -> miss
        v = '{32'sh10000, 32'sh10000, 32'sh10000, 32'sh20000, 32'sh20000, 32'sh20000,
              0, 0, 0, -32'sh10000, -32'sh10000, -32'sh10000};
        send_ray(v);
        // all directions zero
        v = '{-32'sh10000, -32'sh10000, -32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000,
              0, 0, 0, 0, 0, 0};
        send_ray(v);
        // huge directions: reciprocals shrink to a couple of lsb
        v = '{-32'sh10000, -32'sh10000, -32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000,
              32'sh5000, 0, 0, WORD_MAX, WORD_MIN, 32'sh7fff0000};
        send_ray(v);
        // direction -1 lsb and +1 lsb: saturated reciprocals and products
        v = '{-32'sh10000, -32'sh10000, -32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000,
              -32'sh30000, 0, 0, 1, -1, 1};
        send_ray(v);
        // inverted box
        v = '{32'sh10000, 32'sh10000, 32'sh10000, -32'sh10000, -32'sh10000, -32'sh10000,
              -32'sh30000, 0, 0, 32'sh10000, 32'sh1000, 32'sh1000};
        send_ray(v);
        // field extremes: all max, all min, all zero, alternating
        foreach (v[i]) v[i] = WORD_MAX;
        send_ray(v);
        foreach (v[i]) v[i] = WORD_MIN;
        send_ray(v);
        foreach (v[i]) v[i] = '0;
        send_ray(v);
        foreach (v[i]) v[i] = (i % 2) ? WORD_MIN : WORD_MAX;
        send_ray(v);
        foreach (v[i]) v[i] = (i % 2) ? WORD_MAX : WORD_MIN;
        send_ray(v);
        // widest differences: min box against far origin
        v = '{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX,
              WORD_MIN, WORD_MAX, WORD_MIN, 32'sh100, -32'sh100, 32'sh7};
        send_ray(v);

        // hold off until the pipe drains completely
        ray_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM - N_CALM)
                calm = 1'b1;
            random_ray(v);
            send_ray(v);
        end
        ray_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // End of run: drain, then let the pipeline settle.
    initial
    begin
        wait (stim_done);
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        if (sb.n_errors == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rabs_pkg.sv
rtl/rabs_recip.sv
rtl/ray_aabb_slab_intersect_unit.sv
rtl/rabs_checker.sv
sim/tb_ray_aabb_slab_intersect_unit.sv
